[src/ckf_pkg.sv]
package ckf_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned IDX_W  = 4;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic REG_MAX_POSITION = 1'b0;
  localparam logic REG_MIN_SPAN     = 1'b1;

  localparam logic [POS_W-1:0]  MAX_POSITION_RESET = 16'd25600;
  localparam logic [POS_W-1:0]  MIN_SPAN_RESET     = 16'd1;
  localparam logic [FRAC_W-1:0] FRAC_ONE           = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRAP_RD,
    ST_WRAP_WAIT,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

[src/ckf_key_mem.sv]
module ckf_key_mem
  import ckf_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [POS_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [POS_W-1:0] rd_data
);

  logic [POS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/ckf_div.sv]
module ckf_div
  import ckf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FRAC_W-1:0] num,
  input  logic [FRAC_W-1:0] den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // num < den, so the remainder always fits in FRAC_W bits.
  logic              busy;
  logic [4:0]        steps;
  logic [FRAC_W-1:0] rem;
  logic [FRAC_W-1:0] divisor;
  logic [FRAC_W:0]   rem_sh;
  logic              take;

  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 5'(QUOT_W);
      end else if (busy) begin
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num;
      divisor <= den;
      quot    <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= FRAC_W'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[FRAC_W-1:0];
      end
      quot <= {quot[QUOT_W-2:0], take};
    end
  end

endmodule

[src/cyclic_keyframe_segment_fraction.sv]
// Keyframe segment search on a cyclic timeline.
// Input channel (in_valid/in_ready) carries items of kind append, clear or
// query with a Q8.8 position. Append and clear give no result; a query
// gives one result item on the output channel
// (out_valid/out_ready): the Q1.16 fraction, the segment's start and end
// key indexes and the wrap flag. Kind 3 is dropped.
// Keys live in a single-port-read synchronous RAM of MAX_KEYS entries.
// A query with n >= 2 keys streams one key per cycle out of the RAM until
// the first key at or above the position, or up to the last key when there
// is none, then runs a restoring divider. When the scan stops at the first
// key, the last key is fetched from the RAM before the calculation. With
// fewer than two keys the scan and the divider are skipped. The divider is
// also skipped for a degenerate span or a fraction of zero or one.
// One item is worked on at a time; in_ready is low while a query runs.
// The result waits in an output register, so the next item is accepted
// while a stalled result is held; a new result waits for that register.
// Reset empties the key list and loads the default period and minimum span.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle; the block does not enforce this.
module cyclic_keyframe_segment_fraction
  import ckf_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [POS_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [POS_W-1:0]  position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FRAC_W-1:0] fraction,
  output logic [IDX_W-1:0]  start_index,
  output logic [IDX_W-1:0]  end_index,
  output logic              wrapped
);

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  state_t state, state_next;

  logic [POS_W-1:0] max_position;
  logic [POS_W-1:0] min_span;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    ia;
  logic             chk_v;
  logic [AW-1:0]    chk_idx;
  logic [POS_W-1:0] q_pos;
  logic [POS_W-1:0] first_key;
  logic [POS_W-1:0] prev_key;
  logic [POS_W-1:0] start_key;
  logic [POS_W-1:0] end_key;
  logic [AW-1:0]    s_idx;
  logic [AW-1:0]    e_idx;
  logic             wrap;
  logic [FRAC_W-1:0] frac;

  logic             accept;
  logic             mem_we;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [POS_W-1:0] rd_data;
  logic             issue;
  logic             hit;
  logic             miss_last;
  logic             out_free;

  logic [FRAC_W-1:0]   e_ext;
  logic [FRAC_W-1:0]   p_ext;
  logic signed [FRAC_W:0] span;
  logic signed [FRAC_W:0] num;
  logic             span_small;
  logic             num_nonpos;
  logic             num_sat;
  logic             div_start;
  logic             div_done;
  logic [QUOT_W-1:0] quot;

  logic [AW+IDX_W-1:0] s_ext;
  logic [AW+IDX_W-1:0] e_ext_idx;

  assign accept   = in_valid && in_ready;
  assign count_m1 = count - CW'(1);
  assign out_free = !out_valid || out_ready;
  assign mem_we   = accept && (kind == KIND_APPEND) && (count < CW'(MAX_KEYS));
  assign issue    = (state == ST_SCAN) && (ia < count);
  assign hit      = chk_v && (rd_data >= q_pos);
  assign miss_last = chk_v && !hit && (chk_idx == count_m1[AW-1:0]);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ia[AW-1:0];
    if (issue) begin
      rd_en = 1'b1;
    end else if (state == ST_WRAP_RD) begin
      rd_en   = 1'b1;
      rd_addr = count_m1[AW-1:0];
    end
  end

  // Segment arithmetic; on a wrap the end key moves one period forward, and
  // so does a position that lies before the first key.
  always_comb begin
    e_ext = {1'b0, end_key};
    p_ext = {1'b0, q_pos};
    if (wrap) begin
      e_ext = e_ext + {1'b0, max_position};
      if (q_pos < first_key) begin
        p_ext = p_ext + {1'b0, max_position};
      end
    end
    span       = $signed({1'b0, e_ext}) - $signed({2'b0, start_key});
    num        = $signed({1'b0, p_ext}) - $signed({2'b0, start_key});
    span_small = span <= $signed({2'b0, min_span});
    num_nonpos = num <= $signed({(FRAC_W+1){1'b0}});
    num_sat    = num >= span;
  end

  assign div_start = (state == ST_CALC) && !span_small && !num_nonpos && !num_sat;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && kind == KIND_QUERY) begin
          state_next = (count > CW'(1)) ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (chk_idx == '0) ? ST_WRAP_RD : ST_CALC;
        end else if (miss_last) begin
          state_next = ST_CALC;
        end
      end
      ST_WRAP_RD:   state_next = ST_WRAP_WAIT;
      ST_WRAP_WAIT: state_next = ST_CALC;
      ST_CALC:      state_next = div_start ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      chk_v        <= 1'b0;
      out_valid    <= 1'b0;
      max_position <= MAX_POSITION_RESET;
      min_span     <= MIN_SPAN_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_MAX_POSITION) begin
          max_position <= cfg_data;
        end else begin
          min_span <= cfg_data;
        end
      end
      if (mem_we) begin
        count <= count + CW'(1);
      end else if (accept && kind == KIND_CLEAR) begin
        count <= '0;
      end
      chk_v <= issue;
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_pos <= position;
      ia    <= '0;
      frac  <= '0;
      s_idx <= '0;
      e_idx <= '0;
      wrap  <= 1'b0;
    end
    if (issue) begin
      ia      <= ia + CW'(1);
      chk_idx <= ia[AW-1:0];
    end
    if (state == ST_SCAN && chk_v) begin
      if (chk_idx == '0) begin
        first_key <= rd_data;
      end
      prev_key <= rd_data;
      if (hit) begin
        e_idx   <= chk_idx;
        end_key <= rd_data;
        if (chk_idx == '0) begin
          wrap <= 1'b1;
        end else begin
          start_key <= prev_key;
          s_idx     <= chk_idx - AW'(1);
        end
      end else if (miss_last) begin
        e_idx     <= '0;
        end_key   <= first_key;
        start_key <= rd_data;
        s_idx     <= chk_idx;
        wrap      <= 1'b1;
      end
    end
    if (state == ST_WRAP_WAIT) begin
      start_key <= rd_data;
      s_idx     <= count_m1[AW-1:0];
    end
    if (state == ST_CALC) begin
      frac <= (!span_small && !num_nonpos && num_sat) ? FRAC_ONE : '0;
    end
    if (state == ST_DIV && div_done) begin
      frac <= {1'b0, quot};
    end
    if (state == ST_OUT && out_free) begin
      fraction    <= frac;
      start_index <= s_ext[IDX_W-1:0];
      end_index   <= e_ext_idx[IDX_W-1:0];
      wrapped     <= wrap;
    end
  end

  assign s_ext     = {{IDX_W{1'b0}}, s_idx};
  assign e_ext_idx = {{IDX_W{1'b0}}, e_idx};

  ckf_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (position),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ckf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num[FRAC_W-1:0]),
    .den   (span[FRAC_W-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

endmodule

[src/ckf_checker.sv]
module ckf_checker
  import ckf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FRAC_W-1:0] fraction,
  input logic [IDX_W-1:0]  start_index,
  input logic [IDX_W-1:0]  end_index,
  input logic              wrapped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fraction)
      && $stable(start_index) && $stable(end_index) && $stable(wrapped)))
    else $error("result item changed while stalled");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fraction <= FRAC_ONE))
    else $error("fraction above one");

  a_wrap_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wrapped) |-> (end_index == '0))
    else $error("wrapped segment does not end at the first key");

  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wrapped && end_index != '0) |-> (start_index == end_index - 4'd1))
    else $error("segment keys are not adjacent");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_QUERY) |=> !in_ready)
    else $error("item accepted while a query runs");

endmodule

bind cyclic_keyframe_segment_fraction ckf_checker u_ckf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .fraction    (fraction),
  .start_index (start_index),
  .end_index   (end_index),
  .wrapped     (wrapped)
);
